// ===== rtl/rea_pkg.sv =====
// ----------------------------------------------------------------------------
// rea_pkg
// shared widths, register indexes, angle constants and the result word type
// ----------------------------------------------------------------------------
`default_nettype none

package rea_pkg;

    localparam int RAW_W    = 16;
    localparam int POS_W    = 12;
    localparam int FLAG_W   = 4;
    localparam int DEG_W    = 9;
    localparam int CYC_W    = 7;
    localparam int PP_W     = 7;
    localparam int OFF_W    = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W    = 11;
    localparam int TDATA_W  = 40;
    localparam int TUSER_W  = 4;
    localparam int DATA_BITS = POS_W + DEG_W + CYC_W + DEG_W;

    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 1'b1;

    localparam logic [DEG_W-1:0] DEG_MAX   = 9'd359;
    localparam logic [SUM_W-1:0] DEG_MOD   = 11'd360;
    localparam logic [SUM_W-1:0] DEG_MOD2  = 11'd720;
    localparam logic [SUM_W-1:0] DEG_MOD3  = 11'd1080;
    // 359 + 359 + 720, folded with the offset at write time
    localparam logic [SUM_W-1:0] CORR_BASE = 11'd1438;

    typedef struct packed {
        logic [FLAG_W-1:0] status_flags;
        logic [DEG_W-1:0]  corrected_degree;
        logic [CYC_W-1:0]  cycle_index;
        logic [DEG_W-1:0]  electrical_degree;
        logic [POS_W-1:0]  position;
    } rea_result_t;

endpackage

`default_nettype wire

// ===== rtl/rea_span_calc.sv =====
// ----------------------------------------------------------------------------
// rea_span_calc
// works out the span per pole pair, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rea_span_calc
    import rea_pkg::*;
#(
    parameter int FULL_SCALE = 4095,
    parameter int SPAN_W     = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic [PP_W-1:0]   pp_in,
    output logic                   busy,
    output logic [SPAN_W-1:0]      span
);

    localparam int CNT_W = $clog2(SPAN_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [PP_W-1:0]   rem_reg;
    logic [SPAN_W-1:0] dvd_reg;
    logic [SPAN_W-1:0] q_reg;
    logic [SPAN_W-1:0] span_reg;

    logic [PP_W:0]     trial;
    logic              ge;
    logic [PP_W-1:0]   rem_next;
    logic [SPAN_W-1:0] q_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[SPAN_W-1]};
        ge       = trial >= {1'b0, pp_reg};
        rem_next = ge ? PP_W'(trial - {1'b0, pp_reg}) : trial[PP_W-1:0];
        q_next   = SPAN_W'({q_reg, ge});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            span_reg <= SPAN_W'(FULL_SCALE);
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SPAN_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                span_reg <= q_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            // zero pole pairs counts as one
            pp_reg  <= (pp_in == '0) ? PP_W'(1) : pp_in;
            rem_reg <= '0;
            dvd_reg <= SPAN_W'(FULL_SCALE);
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;
    assign span = span_reg;

endmodule

`default_nettype wire

// ===== rtl/rea_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rea_div_pipe
// restoring divider, one quotient bit per pipeline stage, side word rides along
// ----------------------------------------------------------------------------
`default_nettype none

module rea_div_pipe #(
    parameter int REM_W  = 12,
    parameter int Q_W    = 12,
    parameter int SIDE_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [REM_W-1:0]  in_rem,
    input  wire logic [Q_W-1:0]    in_dvd,
    input  wire logic [SIDE_W-1:0] in_side,
    input  wire logic [REM_W-1:0]  divisor,
    output logic                   out_valid,
    output logic [Q_W-1:0]         out_q,
    output logic [REM_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg [Q_W];
    logic [REM_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    dvd_reg   [Q_W];
    logic [Q_W-1:0]    q_reg     [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic              v_src;
        logic [REM_W-1:0]  rem_src;
        logic [Q_W-1:0]    dvd_src;
        logic [Q_W-1:0]    q_src;
        logic [SIDE_W-1:0] side_src;
        logic [REM_W:0]    trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [Q_W-1:0]    q_next;

        if (i == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = in_rem;
            assign dvd_src  = in_dvd;
            assign q_src    = '0;
            assign side_src = in_side;
        end else begin : g_next
            assign v_src    = valid_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign dvd_src  = dvd_reg[i-1];
            assign q_src    = q_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        always_comb begin
            trial    = {rem_src, dvd_src[Q_W-1]};
            ge       = trial >= {1'b0, divisor};
            rem_next = ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
            q_next   = Q_W'({q_src, ge});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                dvd_reg[i]  <= dvd_src << 1;
                q_reg[i]    <= q_next;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_q     = q_reg[Q_W-1];
    assign out_rem   = rem_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/rea_out_buf.sv =====
// ----------------------------------------------------------------------------
// rea_out_buf
// output register plus skid entry, holds the pipeline only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module rea_out_buf
    import rea_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire rea_result_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    output rea_result_t      out_data,
    input  wire logic        out_ready
);

    logic        out_valid_reg;
    rea_result_t out_data_reg;
    logic        skid_valid_reg;
    rea_result_t skid_data_reg;
    logic        take;
    logic        drain;

    assign take  = in_valid && !skid_valid_reg;
    assign drain = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (drain) begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (take) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/resolver_electrical_angle.sv =====
// ----------------------------------------------------------------------------
// resolver_electrical_angle
// resolver word to electrical and offset-corrected angle, fully pipelined
// ----------------------------------------------------------------------------
// Takes one word per cycle while s_tready is high and returns one result
// word per input word, in order, after 12 stages dividing position by span,
// one multiply stage, 9 stages for the degree quotient, one angle stage and
// one output register. After a pole_pairs write, s_tready stays low while
// the span divider in rea_span_calc shifts out one bit per cycle. A stalled
// m_tready is absorbed by an output register and one skid entry.
`default_nettype none

module resolver_electrical_angle
    import rea_pkg::*;
#(
    parameter int POSITION_FULL_SCALE = 4095
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [RAW_W-1:0]     s_tdata,   // raw_word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // position, electrical_degree, cycle_index, corrected_degree, zero pad
    output logic [TDATA_W-1:0]        m_tdata,
    output logic [TUSER_W-1:0]        m_tuser,   // status_flags
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int SPAN_W  = $clog2(POSITION_FULL_SCALE + 1);
    localparam int PROD_W  = SPAN_W + DEG_W;
    localparam int SIDE1_W = RAW_W;
    localparam int SIDE2_W = RAW_W + CYC_W;

    logic               en;
    logic               busy;
    logic [SPAN_W-1:0]  span;
    logic [SUM_W-1:0]   base_reg;
    logic               in_fire;

    logic               d1_valid;
    logic [POS_W-1:0]   d1_q;
    logic [SPAN_W-1:0]  d1_rem;
    logic [SIDE1_W-1:0] d1_side;

    logic               mul_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SIDE2_W-1:0] mul_side_reg;

    logic               d2_valid;
    logic [DEG_W-1:0]   d2_q;
    logic [SIDE2_W-1:0] d2_side;

    logic [SUM_W-1:0]   sum;
    logic [DEG_W-1:0]   corr;
    logic               res_valid_reg;
    rea_result_t        res_reg;
    rea_result_t        res_out;

    rea_span_calc #(
        .FULL_SCALE (POSITION_FULL_SCALE),
        .SPAN_W     (SPAN_W)
    ) u_span (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cfg_we && cfg_index == REG_POLE_PAIRS),
        .pp_in   (cfg_wdata[PP_W-1:0]),
        .busy    (busy),
        .span    (span)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= CORR_BASE;
        end else if (cfg_we && cfg_index == REG_ANGLE_OFFSET) begin
            base_reg <= CORR_BASE - SUM_W'(cfg_wdata[OFF_W-1:0]);
        end
    end

    assign s_tready = en && !busy;
    assign in_fire  = s_tvalid && s_tready;

    // cycle index and position within the span
    rea_div_pipe #(
        .REM_W  (SPAN_W),
        .Q_W    (POS_W),
        .SIDE_W (SIDE1_W)
    ) u_div_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_fire),
        .in_rem    ('0),
        .in_dvd    (s_tdata[RAW_W-1:FLAG_W]),
        .in_side   (s_tdata),
        .divisor   (span),
        .out_valid (d1_valid),
        .out_q     (d1_q),
        .out_rem   (d1_rem),
        .out_side  (d1_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg     <= PROD_W'(d1_rem) * PROD_W'(DEG_MAX);
            mul_side_reg <= {d1_q[CYC_W-1:0], d1_side};
        end
    end

    // quotient stays below 359, so the upper product bits start as remainder
    rea_div_pipe #(
        .REM_W  (SPAN_W),
        .Q_W    (DEG_W),
        .SIDE_W (SIDE2_W)
    ) u_div_deg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mul_valid_reg),
        .in_rem    (prod_reg[PROD_W-1:DEG_W]),
        .in_dvd    (prod_reg[DEG_W-1:0]),
        .in_side   (mul_side_reg),
        .divisor   (span),
        .out_valid (d2_valid),
        .out_q     (d2_q),
        .out_rem   (),
        .out_side  (d2_side)
    );

    always_comb begin
        sum = base_reg - SUM_W'(d2_q);
        priority if (sum >= DEG_MOD3) begin
            corr = DEG_W'(sum - DEG_MOD3);
        end else if (sum >= DEG_MOD2) begin
            corr = DEG_W'(sum - DEG_MOD2);
        end else if (sum >= DEG_MOD) begin
            corr = DEG_W'(sum - DEG_MOD);
        end else begin
            corr = DEG_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.position          <= d2_side[RAW_W-1:FLAG_W];
            res_reg.status_flags      <= d2_side[FLAG_W-1:0];
            res_reg.cycle_index       <= d2_side[SIDE2_W-1:RAW_W];
            res_reg.electrical_degree <= DEG_MAX - d2_q;
            res_reg.corrected_degree  <= corr;
        end
    end

    rea_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid_reg),
        .in_data   (res_reg),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_data  (res_out),
        .out_ready (m_tready)
    );

    assign m_tdata = {(TDATA_W - DATA_BITS)'(0), res_out.corrected_degree,
                      res_out.cycle_index, res_out.electrical_degree, res_out.position};
    assign m_tuser = res_out.status_flags;

endmodule

`default_nettype wire

// ===== rtl/rea_checker.sv =====
// ----------------------------------------------------------------------------
// rea_checker
// port-level checks on the resolver angle block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rea_checker
    import rea_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [TDATA_W-1:0]   m_tdata,
    input wire logic [TUSER_W-1:0]   m_tuser,
    input wire logic                 cfg_we,
    input wire logic [CFG_IDX_W-1:0] cfg_index
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // both angles stay in 0..359 and the pad bits stay zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:12] <= DEG_MAX && m_tdata[36:28] <= DEG_MAX
                     && m_tdata[TDATA_W-1:DATA_BITS] == '0)
        else $error("angle out of range");

    // span recompute blocks input right after a pole pair write
    a_pp_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && cfg_we && cfg_index == REG_POLE_PAIRS |=> !s_tready)
        else $error("input accepted during span recompute");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind resolver_electrical_angle rea_checker u_rea_checker (.*);

`default_nettype wire
